// ----- rtl/core/nearest_center_assign_top_defines.svh -----
// assertion macros used by the checker
`ifndef NEAREST_CENTER_ASSIGN_TOP_DEFINES_SVH
`define NEAREST_CENTER_ASSIGN_TOP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define NCA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define NCA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/nca_pkg.sv -----
package nca_pkg;

	// field widths
	localparam int COORD_W  = 16;
	localparam int IDX_W    = 6;
	localparam int CCNT_W   = 7;
	localparam int DIST_W   = 33;
	localparam int SQ_W     = 2 * COORD_W;
	localparam int SLOTS    = 1 << IDX_W;
	localparam int CFG_IDX_W = 1;

	// limit after reset: 1e5 in q16.16
	localparam logic [DIST_W-1:0] LIMIT_RESET = 33'd6553600000;

	// request function codes
	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_ASSIGN = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST     = 1'b1;

	typedef struct packed {
		logic                      func;
		logic [IDX_W-1:0]          center_index;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic                      last_in_batch;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0]  nearest_index;
		logic              found;
		logic [DIST_W-1:0] distance_squared;
		logic              batch_end;
	} rsp_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} center_t;

	// center memory port controls
	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		center_t          wr_data;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
	} mem_req_t;

	typedef enum logic [1:0] {
		SC_IDLE,
		SC_SCAN,
		SC_DRAIN,
		SC_DONE
	} scan_state_t;

endpackage

// ----- rtl/core/nearest_center_assign_top.sv -----
// nearest center assignment
// req channel (valid/stall) carries one item per transfer. func write stores
// (x, y) as a center; func assign scans centers 0 .. n-1 and
// returns the index of the first one with the smallest squared distance that
// lies strictly below max_distance_squared, or found = 0 with zero fields.
// n is center_count capped at NUM_CENTERS (and at 64 slots).
// centers live in one synchronous memory read once per cycle. req_stall stays
// high from an assign transfer until its result is loaded into the output
// register. a write item never raises req_stall, and the next item may follow
// at once.
// the result sits in an output register: the scan of the following item runs
// while a result is held; the scanner waits at its end only if rsp is still
// stalled. a stalled rsp holds its payload unchanged.
// cfg_we writes register cfg_index (0 center_count, 1 max_distance_squared)
// and must only be used while no assign is in flight.
// reset clears the sequencer, the output valid and the registers
// (center_count 0, limit 1e5 in q16.16); the center memory is not cleared.
module nearest_center_assign_top #(
	parameter int NUM_CENTERS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  nca_pkg::req_t                   req,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output nca_pkg::rsp_t                   rsp,
	input  logic                            cfg_we,
	input  logic [nca_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [nca_pkg::DIST_W-1:0]      cfg_data
);
	import nca_pkg::*;

	localparam int DEPTH = (NUM_CENTERS < SLOTS) ? NUM_CENTERS : SLOTS;

	logic [CCNT_W-1:0] center_count_q;
	logic [DIST_W-1:0] max_dist_q;
	mem_req_t          mem_req;
	center_t           rd_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_count_q <= '0;
			max_dist_q     <= LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CENTER_COUNT: center_count_q <= cfg_data[CCNT_W-1:0];
				CFG_MAX_DIST:     max_dist_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// center memory
	nca_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk     (clk),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

	// scan sequencer and distance pipeline
	nca_scan #(
		.DEPTH(DEPTH)
	) u_scan (
		.clk                  (clk),
		.arst_n               (arst_n),
		.req_valid            (req_valid),
		.req_stall            (req_stall),
		.req                  (req),
		.center_count         (center_count_q),
		.max_distance_squared (max_dist_q),
		.mem_req              (mem_req),
		.rd_data              (rd_data),
		.rsp_valid            (rsp_valid),
		.rsp_stall            (rsp_stall),
		.rsp                  (rsp)
	);

endmodule

// ----- rtl/core/nca_mem.sv -----
module nca_mem #(
	parameter int DEPTH = 64
) (
	input  logic              clk,
	input  nca_pkg::mem_req_t mem_req,
	output nca_pkg::center_t  rd_data
);
	import nca_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	center_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (mem_req.wr_en) begin
			mem[mem_req.wr_addr[AW-1:0]] <= mem_req.wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (mem_req.rd_en) begin
			rd_data <= mem[mem_req.rd_addr[AW-1:0]];
		end
	end

endmodule

// ----- rtl/core/nca_scan.sv -----
module nca_scan #(
	parameter int DEPTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  nca_pkg::req_t               req,
	input  logic [nca_pkg::CCNT_W-1:0]  center_count,
	input  logic [nca_pkg::DIST_W-1:0]  max_distance_squared,
	output nca_pkg::mem_req_t           mem_req,
	input  nca_pkg::center_t            rd_data,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output nca_pkg::rsp_t               rsp
);
	import nca_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	scan_state_t state_q, state_d;

	logic req_acc, start, issue, last_issue, load_rsp, pipe_busy;
	logic [CW-1:0] n_d, n_q, cnt_q;

	logic signed [COORD_W-1:0] px_q, py_q;
	logic                      last_q;

	logic                      valid_s1, valid_s2, valid_s3, valid_s4;
	logic [AW-1:0]             idx_s1, idx_s2, idx_s3, idx_s4;
	logic signed [COORD_W:0]   dx_s2, dy_s2;
	logic signed [2*COORD_W+1:0] prod_x, prod_y;
	logic [SQ_W-1:0]           sqx_s3, sqy_s3;
	logic [DIST_W-1:0]         dist_s4;

	logic                      found_q, better;
	logic [AW-1:0]             best_idx_q;
	logic [DIST_W-1:0]         best_d_q;

	logic                      rsp_valid_q;
	rsp_t                      rsp_q;

	// input transfer decode
	assign req_stall = (state_q != SC_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign start     = req_acc && (req.func == FUNC_ASSIGN);

	// centers in use, capped at the memory depth
	assign n_d = (center_count > CCNT_W'(DEPTH)) ? CW'(DEPTH) : CW'(center_count);

	// memory port: writes on transfer, reads while scanning
	always_comb begin
		mem_req.wr_en   = req_acc && (req.func == FUNC_WRITE) &&
			({1'b0, req.center_index} < CCNT_W'(DEPTH));
		mem_req.wr_addr = req.center_index;
		mem_req.wr_data = '{x: req.x, y: req.y};
		mem_req.rd_en   = issue;
		mem_req.rd_addr = IDX_W'(cnt_q[AW-1:0]);
	end

	assign last_issue = (CW'(cnt_q + 1'b1) == n_q);
	assign pipe_busy  = valid_s1 || valid_s2 || valid_s3 || valid_s4;

	// next state and sequencer outputs
	always_comb begin
		state_d  = state_q;
		issue    = 1'b0;
		load_rsp = 1'b0;
		unique case (state_q)
			SC_IDLE: begin
				if (start) begin
					state_d = (n_d == '0) ? SC_DONE : SC_SCAN;
				end
			end
			SC_SCAN: begin
				issue = 1'b1;
				if (last_issue) begin
					state_d = SC_DRAIN;
				end
			end
			SC_DRAIN: begin
				if (!pipe_busy) begin
					state_d = SC_DONE;
				end
			end
			SC_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					load_rsp = 1'b1;
					state_d  = SC_IDLE;
				end
			end
			default: state_d = SC_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control: counters, stage valids, best flag, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= '0;
			cnt_q       <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			if (start) begin
				n_q     <= n_d;
				cnt_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (issue) begin
					cnt_q <= CW'(cnt_q + 1'b1);
				end
				if (valid_s4 && better) begin
					found_q <= 1'b1;
				end
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_stall == 1'b0) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// squares of the coordinate differences
	assign prod_x = dx_s2 * dx_s2;
	assign prod_y = dy_s2 * dy_s2;

	// strictly inside the limit and strictly closer than the best so far
	assign better = (dist_s4 < max_distance_squared) && (!found_q || (dist_s4 < best_d_q));

	// distance pipeline and best tracking
	always_ff @(posedge clk) begin
		if (start) begin
			px_q       <= req.x;
			py_q       <= req.y;
			last_q     <= req.last_in_batch;
			best_idx_q <= '0;
			best_d_q   <= '0;
		end else if (valid_s4 && better) begin
			best_idx_q <= idx_s4;
			best_d_q   <= dist_s4;
		end
		idx_s1 <= cnt_q[AW-1:0];
		// stage 2: differences
		idx_s2 <= idx_s1;
		dx_s2  <= $signed({px_q[COORD_W-1], px_q}) - $signed({rd_data.x[COORD_W-1], rd_data.x});
		dy_s2  <= $signed({py_q[COORD_W-1], py_q}) - $signed({rd_data.y[COORD_W-1], rd_data.y});
		// stage 3: squares, each below 2^(2*COORD_W)
		idx_s3 <= idx_s2;
		sqx_s3 <= prod_x[SQ_W-1:0];
		sqy_s3 <= prod_y[SQ_W-1:0];
		// stage 4: sum, which never exceeds the 33-bit range
		idx_s4  <= idx_s3;
		dist_s4 <= DIST_W'(sqx_s3) + DIST_W'(sqy_s3);
		// result register
		if (load_rsp) begin
			rsp_q.nearest_index    <= IDX_W'(best_idx_q);
			rsp_q.found            <= found_q;
			rsp_q.distance_squared <= best_d_q;
			rsp_q.batch_end        <= last_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- rtl/core/nca_checker.sv -----
`include "nearest_center_assign_top_defines.svh"

module nca_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input nca_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input nca_pkg::rsp_t rsp
);
	import nca_pkg::*;

	logic req_acc;
	logic miss_clean;

	// input transfer and the zero fields of a miss
	assign req_acc    = req_valid && !req_stall;
	assign miss_clean = (rsp.nearest_index == '0) && (rsp.distance_squared == '0);

	// a stalled result stays offered and unchanged
	`NCA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp changed")

	// a miss carries zero index and distance
	`NCA_ASSERT_SAME(a_miss_zero, rsp_valid && !rsp.found, miss_clean, "miss with nonzero fields")

	// an assign transfer occupies the scanner
	`NCA_ASSERT_NEXT(a_assign_busy, req_acc && (req.func == FUNC_ASSIGN), req_stall, "open after assign")

	// a write transfer leaves the scanner free
	`NCA_ASSERT_NEXT(a_write_free, req_acc && (req.func == FUNC_WRITE), !req_stall, "stall after write")

endmodule

bind nearest_center_assign_top nca_checker u_nca_checker (.*);
